/* hdl/bgpp_pkg.sv */
// Package with phase codes, record kinds, error codes and result record type.
`timescale 1ns / 1ps
package bgpp_pkg;

    typedef enum logic [3:0] {
        PH_HEAD      = 4'd0,
        PH_SKIP_BODY = 4'd1,
        PH_WD_LEN_HI = 4'd2,
        PH_WD_LEN_LO = 4'd3,
        PH_WD_PREFIX = 4'd4,
        PH_WD_OCTETS = 4'd5,
        PH_AT_LEN_HI = 4'd6,
        PH_AT_LEN_LO = 4'd7,
        PH_AT_FLAGS  = 4'd8,
        PH_AT_TYPE   = 4'd9,
        PH_AT_LEN    = 4'd10,
        PH_AT_DATA   = 4'd11,
        PH_NL_PREFIX = 4'd12,
        PH_NL_OCTETS = 4'd13,
        PH_WD_SKIP   = 4'd14,
        PH_DISCARD   = 4'd15
    } phase_t;

    localparam logic [2:0] K_HEADER    = 3'd0;
    localparam logic [2:0] K_WITHDRAWN = 3'd1;
    localparam logic [2:0] K_ATTR_HDR  = 3'd2;
    localparam logic [2:0] K_ATTR_DATA = 3'd3;
    localparam logic [2:0] K_NLRI      = 3'd4;
    localparam logic [2:0] K_ERROR     = 3'd5;

    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_SHORT     = 3'd1;
    localparam logic [2:0] E_TYPE      = 3'd2;
    localparam logic [2:0] E_PREFIX    = 3'd3;
    localparam logic [2:0] E_TRUNC     = 3'd4;

    localparam logic [15:0] HDR_BYTES  = 16'd19;
    localparam logic [7:0]  LIMIT_RST  = 8'd32;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [7:0]  message_type;
        logic [15:0] message_length;
        logic [5:0]  prefix_length;
        logic [31:0] route_address;
        logic [7:0]  attr_flags;
        logic [7:0]  attr_type;
        logic [7:0]  attr_length;
        logic [7:0]  data_value;
        logic [2:0]  error_code;
        logic        record_last;
    } rec_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_end;
    } in_t;

endpackage

/* hdl/bgpp_if.sv */
// Valid/ready channel interfaces for input bytes, result records and config.
`timescale 1ns / 1ps
interface bgpp_in_if;
    import bgpp_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_end;
    modport source (output valid, payload_byte, payload_end, input ready);
    modport sink (input valid, payload_byte, payload_end, output ready);
endinterface

interface bgpp_out_if;
    import bgpp_pkg::*;
    logic  valid;
    logic  ready;
    rec_t  rec;
    modport source (output valid, rec, input ready);
    modport sink (input valid, rec, output ready);
endinterface

interface bgpp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* hdl/bgpp_core.sv */
// Parser state and per-byte record generation (up to two records per byte).
`timescale 1ns / 1ps
module bgpp_core
    import bgpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  in_t        item,
    input  logic [7:0] limit,
    output logic [1:0] rec_cnt,
    output rec_t       rec0,
    output rec_t       rec1
);

    phase_t      phase_reg, phase_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  typ_reg, typ_next;
    logic [15:0] sec_reg, sec_next;
    logic [5:0]  pfx_reg, pfx_next;
    logic [2:0]  oct_reg, oct_next;
    logic [31:0] addr_reg, addr_next;
    logic [23:0] ahdr_reg, ahdr_next;
    logic [7:0]  aoff_reg, aoff_next;

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
            cnt_reg   <= '0;
            len_reg   <= '0;
            typ_reg   <= '0;
            sec_reg   <= '0;
            pfx_reg   <= '0;
            oct_reg   <= '0;
            addr_reg  <= '0;
            ahdr_reg  <= '0;
            aoff_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            typ_reg   <= typ_next;
            sec_reg   <= sec_next;
            pfx_reg   <= pfx_next;
            oct_reg   <= oct_next;
            addr_reg  <= addr_next;
            ahdr_reg  <= ahdr_next;
            aoff_reg  <= aoff_next;
        end
    end

    logic [7:0]  b;
    logic        in_sec;
    logic [15:0] left;
    logic [15:0] raw;
    logic [2:0]  got;
    logic        wd;
    logic        pfx_ok;
    rec_t        rs [2];
    logic [1:0]  n;

    // Compute next state and records for one byte
    always_comb
    begin
        b = item.payload_byte;
        phase_next = phase_reg;
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        typ_next  = typ_reg;
        sec_next  = sec_reg;
        pfx_next  = pfx_reg;
        oct_next  = oct_reg;
        addr_next = addr_reg;
        ahdr_next = ahdr_reg;
        aoff_next = aoff_reg;
        rs[0] = '0;
        rs[1] = '0;
        n = 2'd0;
        raw = '0;
        got = '0;
        wd = 1'b0;
        pfx_ok = (b == 8'd8) || (b == 8'd16) || (b == 8'd24) || (b == 8'd32);
        in_sec = (phase_reg >= PH_WD_PREFIX) && (phase_reg <= PH_WD_SKIP)
                 && (phase_reg != PH_AT_LEN_HI) && (phase_reg != PH_AT_LEN_LO);
        if (phase_reg != PH_DISCARD)
            cnt_next = cnt_reg + 16'd1;
        left = (len_reg > cnt_next) ? len_reg - cnt_next : 16'd0;
        if (in_sec && sec_reg != 16'd0)
            sec_next = sec_reg - 16'd1;

        case (phase_reg)
            PH_HEAD:
            begin
                if (cnt_reg == 16'd16)
                    len_next = {b, 8'd0};
                else if (cnt_reg == 16'd17)
                    len_next = {len_reg[15:8], b};
                else if (cnt_reg >= 16'd18)
                begin
                    typ_next = b;
                    rs[0].record_kind = K_HEADER;
                    n = 2'd1;
                    if (len_reg < HDR_BYTES)
                    begin
                        rs[0].record_kind = K_ERROR;
                        rs[0].error_code = E_SHORT;
                        phase_next = PH_DISCARD;
                    end
                    else if (b < 8'd1 || b > 8'd5)
                    begin
                        rs[0].record_kind = K_ERROR;
                        rs[0].error_code = E_TYPE;
                        phase_next = PH_DISCARD;
                    end
                    else
                        phase_next = (b == 8'd2) ? PH_WD_LEN_HI : PH_SKIP_BODY;
                end
            end
            PH_WD_LEN_HI, PH_AT_LEN_HI:
            begin
                sec_next = {b, 8'd0};
                phase_next = phase_t'(phase_reg + 4'd1);
            end
            PH_WD_LEN_LO, PH_AT_LEN_LO:
            begin
                raw = {sec_reg[15:8], b};
                if (raw > left)
                    raw = left;
                sec_next = raw;
                if (phase_reg == PH_WD_LEN_LO)
                    phase_next = (raw != 16'd0) ? PH_WD_PREFIX : PH_AT_LEN_HI;
                else if (raw != 16'd0)
                    phase_next = PH_AT_FLAGS;
                else
                begin
                    sec_next = left;
                    phase_next = PH_NL_PREFIX;
                end
            end
            PH_WD_PREFIX, PH_NL_PREFIX:
            begin
                wd = (phase_reg == PH_WD_PREFIX);
                if (pfx_ok)
                begin
                    pfx_next = b[5:0];
                    oct_next = b[5:3];
                    addr_next = '0;
                    phase_next = wd ? PH_WD_OCTETS : PH_NL_OCTETS;
                end
                else
                begin
                    rs[0].record_kind = K_ERROR;
                    rs[0].error_code = E_PREFIX;
                    n = 2'd1;
                    phase_next = wd ? PH_WD_SKIP : PH_SKIP_BODY;
                end
            end
            PH_WD_OCTETS, PH_NL_OCTETS:
            begin
                wd = (phase_reg == PH_WD_OCTETS);
                got = pfx_reg[5:3] - oct_reg;
                case (got)
                    3'd0: addr_next = addr_reg | {b, 24'd0};
                    3'd1: addr_next = addr_reg | {8'd0, b, 16'd0};
                    3'd2: addr_next = addr_reg | {16'd0, b, 8'd0};
                    3'd3: addr_next = addr_reg | {24'd0, b};
                    default: addr_next = addr_reg;
                endcase
                if (oct_reg != 3'd0)
                    oct_next = oct_reg - 3'd1;
                if (oct_next == 3'd0)
                begin
                    rs[0].record_kind = wd ? K_WITHDRAWN : K_NLRI;
                    rs[0].prefix_length = pfx_reg;
                    rs[0].route_address = addr_next;
                    n = 2'd1;
                    phase_next = wd ? PH_WD_PREFIX : PH_NL_PREFIX;
                end
            end
            PH_AT_FLAGS:
            begin
                ahdr_next = {b, 16'd0};
                phase_next = PH_AT_TYPE;
            end
            PH_AT_TYPE:
            begin
                ahdr_next = {ahdr_reg[23:16], b, 8'd0};
                phase_next = PH_AT_LEN;
            end
            PH_AT_LEN:
            begin
                ahdr_next = {ahdr_reg[23:8], b};
                aoff_next = '0;
                rs[0].record_kind = K_ATTR_HDR;
                {rs[0].attr_flags, rs[0].attr_type, rs[0].attr_length} = ahdr_next;
                n = 2'd1;
                phase_next = (b != 8'd0) ? PH_AT_DATA : PH_AT_FLAGS;
            end
            PH_AT_DATA:
            begin
                if (aoff_reg < limit)
                begin
                    rs[0].record_kind = K_ATTR_DATA;
                    {rs[0].attr_flags, rs[0].attr_type, rs[0].attr_length} = ahdr_reg;
                    rs[0].data_value = b;
                    n = 2'd1;
                end
                aoff_next = aoff_reg + 8'd1;
                if (aoff_next >= ahdr_reg[7:0])
                    phase_next = PH_AT_FLAGS;
            end
            default:
            begin
            end
        endcase

        // Close a section whose byte budget ran out
        if (in_sec && sec_next == 16'd0)
        begin
            case (phase_next)
                PH_WD_OCTETS:
                begin
                    rs[n[0]].record_kind = K_WITHDRAWN;
                    rs[n[0]].prefix_length = pfx_next;
                    rs[n[0]].route_address = addr_next;
                    n = n + 2'd1;
                    phase_next = PH_AT_LEN_HI;
                end
                PH_WD_PREFIX, PH_WD_SKIP:
                    phase_next = PH_AT_LEN_HI;
                PH_AT_TYPE, PH_AT_LEN:
                begin
                    rs[n[0]].record_kind = K_ATTR_HDR;
                    {rs[n[0]].attr_flags, rs[n[0]].attr_type,
                     rs[n[0]].attr_length} = ahdr_next;
                    n = n + 2'd1;
                    sec_next = left;
                    phase_next = PH_NL_PREFIX;
                end
                PH_AT_FLAGS, PH_AT_DATA:
                begin
                    sec_next = left;
                    phase_next = PH_NL_PREFIX;
                end
                PH_NL_OCTETS:
                begin
                    rs[n[0]].record_kind = K_NLRI;
                    rs[n[0]].prefix_length = pfx_next;
                    rs[n[0]].route_address = addr_next;
                    n = n + 2'd1;
                    phase_next = PH_SKIP_BODY;
                end
                default:
                    phase_next = PH_SKIP_BODY;
            endcase
        end

        // Wrap to the next message header at the message end
        if (phase_next != PH_HEAD && phase_next != PH_DISCARD && cnt_next == len_next)
        begin
            phase_next = PH_HEAD;
            cnt_next = '0;
        end

        // Flag truncation and restart at payload end
        if (item.payload_end)
        begin
            if (phase_next != PH_DISCARD && !(phase_next == PH_HEAD && cnt_next == 16'd0)
                && n != 2'd2)
            begin
                rs[n[0]].record_kind = K_ERROR;
                rs[n[0]].error_code = E_TRUNC;
                n = n + 2'd1;
            end
            phase_next = PH_HEAD;
            cnt_next  = '0;
            len_next  = '0;
            typ_next  = '0;
            sec_next  = '0;
            pfx_next  = '0;
            oct_next  = '0;
            addr_next = '0;
            ahdr_next = '0;
            aoff_next = '0;
        end

        // Type and length are those at emit time, before any clear
        rs[0].message_type = typ_next;
        rs[1].message_type = typ_next;
        rs[0].message_length = len_next;
        rs[1].message_length = len_next;
        if (item.payload_end && phase_reg == PH_HEAD)
        begin
            rs[0].message_type = (cnt_reg >= 16'd18) ? b : typ_reg;
            rs[1].message_type = (cnt_reg >= 16'd18) ? b : typ_reg;
        end
        if (item.payload_end)
        begin
            rs[0].message_type = (phase_reg == PH_HEAD && cnt_reg >= 16'd18) ? b : typ_reg;
            rs[1].message_type = rs[0].message_type;
            rs[0].message_length = (phase_reg == PH_HEAD && cnt_reg == 16'd16) ? {b, 8'd0} :
                                   (phase_reg == PH_HEAD && cnt_reg == 16'd17) ?
                                   {len_reg[15:8], b} : len_reg;
            rs[1].message_length = rs[0].message_length;
        end
        rs[0].record_last = (n == 2'd1);
        rs[1].record_last = 1'b1;
        rec0 = rs[0];
        rec1 = rs[1];
        rec_cnt = n;
    end

endmodule

/* hdl/bgpp_outq.sv */
// Three-record output stage: holds results of accepted bytes and drains them in order.
`timescale 1ns / 1ps
module bgpp_outq
    import bgpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [1:0] load_cnt,
    input  rec_t       load0,
    input  rec_t       load1,
    output logic       can_load,
    bgpp_out_if.source out
);

    rec_t       q_reg [3];
    rec_t       q_next [3];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] base;
    logic       pop;

    assign pop = out.valid && out.ready;
    // Accept a new byte while at most one record is held; room stays for two more
    assign can_load = (cnt_reg <= 2'd1);
    assign out.valid = (cnt_reg != 2'd0);
    assign out.rec = q_reg[0];

    // Shift out the taken record, then append the records of a loaded byte
    always_comb
    begin
        q_next = q_reg;
        base = cnt_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            base = cnt_reg - 2'd1;
        end
        if (load)
        begin
            case (base)
                2'd0:
                begin
                    q_next[0] = load0;
                    q_next[1] = load1;
                end
                2'd1:
                begin
                    q_next[1] = load0;
                    q_next[2] = load1;
                end
                default:
                begin
                end
            endcase
        end
        cnt_next = base + (load ? load_cnt : 2'd0);
    end

    // Advance the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

/* hdl/bgp_message_stream_parser_top.sv */
// Top level of the BGP message stream parser.
//
// Channels: in (payload_byte, payload_end) takes one payload byte per item,
// payload_end marking the final byte. out carries result records (rec struct: kind,
// message type/length, route, attribute header and data, error code, record_last).
// cfg writes attr_data_limit (reset 32); user writes only while idle, unenforced.
// Each byte is parsed in the cycle it is accepted; its zero, one or two
// records appear in the three-entry output stage on the next cycle.
// Throughput: one byte per cycle while each byte gives at most one record and
// the receiver takes a record every cycle; after a byte with two records the
// input is held back while the single output port drains the extra record.
// in.ready is high while the output stage holds at most one record, so it does
// not depend on out.ready; a receiver stall fills the stage, then holds the
// input back until records drain.
// Reset clears the parser to the start of a message header and empties the
// output stage; no clearing pass is needed.
`timescale 1ns / 1ps
module bgp_message_stream_parser_top
    import bgpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bgpp_in_if.sink     in,
    bgpp_out_if.source  out,
    bgpp_cfg_if.sink    cfg
);

    logic [7:0] limit_reg;
    logic       can_load;
    logic       step;
    logic [1:0] rec_cnt;
    rec_t       rec0, rec1;
    in_t        item;

    assign cfg.ready = 1'b1;
    assign in.ready = can_load;
    assign step = in.valid && can_load;
    assign item = '{payload_byte: in.payload_byte, payload_end: in.payload_end};

    // Hold the attribute data limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RST;
        else if (cfg.valid)
            limit_reg <= cfg.data;
    end

    bgpp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .item    (item),
        .limit   (limit_reg),
        .rec_cnt (rec_cnt),
        .rec0    (rec0),
        .rec1    (rec1)
    );

    bgpp_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .load_cnt (rec_cnt),
        .load0    (rec0),
        .load1    (rec1),
        .can_load (can_load),
        .out      (out)
    );

endmodule

/* hdl/bgpp_checker.sv */
// Port-level checker for the parser, bound to the top level.
`timescale 1ns / 1ps
module bgpp_checker
    import bgpp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input rec_t out_rec
);

    // A stalled record holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_rec))
        else $error("stalled record changed");

    // A stage that holds the input back keeps holding it while the receiver stalls
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && !in_ready |=> !in_ready)
        else $error("input ready during stall");

    // Error records carry a code, others none
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_rec.record_kind == K_ERROR) == (out_rec.error_code != E_NONE)))
        else $error("error code mismatch");

    // A record that is not last is followed by another
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_rec.record_last |=> out_valid)
        else $error("record sequence broken");

endmodule

bind bgp_message_stream_parser_top bgpp_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .out_rec   (out.rec)
);
